// ===== design/ioslw_pkg.sv =====
// Package for the second-level IOMMU walk core: store geometry, status and
// item-kind codes, and the item record passed from the front end to the walker.
// No dependencies.
`default_nettype none

package ioslw_pkg;

  // Table store, 64-bit words. Depth must be a power of two; addresses wrap on it.
  localparam int STORE_WORDS = 4096;
  localparam int ADDR_W      = $clog2(STORE_WORDS);

  // Item queue between front end and walker. Depth is a power of two.
  localparam int QDEPTH = 2;
  localparam int QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  // Port field widths
  localparam int WIDX_W    = 12;
  localparam int S_TDATA_W = 168;
  localparam int M_TDATA_W = 72;

  // Configuration register indexes
  localparam logic CFG_TABLES_READY = 1'b0;
  localparam logic CFG_ROOT_ADDR    = 1'b1;

  // Request kinds on tuser
  localparam logic REQ_WRITE     = 1'b0;
  localparam logic REQ_TRANSLATE = 1'b1;

  localparam logic [2:0] AW_3LEVEL = 3'd1;

  typedef enum logic [2:0] {
    ST_OK          = 3'd0,
    ST_NOT_READY   = 3'd1,
    ST_INVALID     = 3'd2,
    ST_NOT_PRESENT = 3'd3,
    ST_UNSUPPORTED = 3'd4
  } status_t;

  // What the walker has to do with a queued item
  typedef enum logic [1:0] {
    K_WRITE = 2'd0,  // store write
    K_WALK  = 2'd1,  // full table walk
    K_DONE  = 2'd2   // status already known
  } kind_t;

  typedef struct packed {
    kind_t               kind;
    logic                wr_ok;     // write index inside the store
    logic [ADDR_W-1:0]   addr;      // write word, or root entry word for a walk
    logic [63:0]         data;
    status_t             status;
    logic [7:0]          ctx_off;   // {dev[4:0], func[2:0]}
    logic                iova_bad;  // iova at or beyond 2^39
    logic [8:0]          pdx;       // iova[38:30]
    logic [29:0]         iova_off;
  } item_t;

endpackage

`default_nettype wire

// ===== design/ioslw_front.sv =====
// Front end: configuration registers, input acceptance and item classification.
// Depends on ioslw_pkg.
`default_nettype none

module ioslw_front
  import ioslw_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 cfg_we,
  input  wire logic                 cfg_index,
  input  wire logic [63:0]          cfg_data,
  input  wire logic                 s_axis_tvalid,
  output      logic                 s_axis_tready,
  input  wire logic [S_TDATA_W-1:0] s_axis_tdata,
  input  wire logic                 s_axis_tuser,
  input  wire logic                 q_full,
  output      logic                 q_push,
  output      item_t                q_item
);

  logic        tables_ready;
  logic [63:0] root_table_addr;

  logic [WIDX_W-1:0] word_index;
  logic [63:0]       word_data;
  logic [7:0]        bus;
  logic [7:0]        dev;
  logic [7:0]        func;
  logic [63:0]       iova;

  always_ff @(posedge clk) begin
    if (rst) begin
      tables_ready    <= 1'b0;
      root_table_addr <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_TABLES_READY: tables_ready    <= cfg_data[0];
        CFG_ROOT_ADDR:    root_table_addr <= cfg_data;
        default:          ;
      endcase
    end
  end

  assign word_index = s_axis_tdata[11:0];
  assign word_data  = s_axis_tdata[75:12];
  assign bus        = s_axis_tdata[83:76];
  assign dev        = s_axis_tdata[91:84];
  assign func       = s_axis_tdata[99:92];
  assign iova       = s_axis_tdata[163:100];

  assign s_axis_tready = !q_full;
  assign q_push        = s_axis_tvalid && !q_full;

  always_comb begin
    q_item          = '0;
    q_item.data     = word_data;
    q_item.ctx_off  = {dev[4:0], func[2:0]};
    q_item.iova_bad = |iova[63:39];
    q_item.pdx      = iova[38:30];
    q_item.iova_off = iova[29:0];
    q_item.status   = ST_OK;
    if (s_axis_tuser == REQ_WRITE) begin
      q_item.kind  = K_WRITE;
      q_item.wr_ok = (32'(word_index) < 32'(STORE_WORDS));
      q_item.addr  = ADDR_W'(word_index);
    end else if (!tables_ready) begin
      q_item.kind   = K_DONE;
      q_item.status = ST_NOT_READY;
    end else if (|dev[7:5] || |func[7:3]) begin
      q_item.kind   = K_DONE;
      q_item.status = ST_INVALID;
    end else begin
      // root entry: 4 KiB aligned base + bus * 16 bytes, i.e. two words per bus
      q_item.kind = K_WALK;
      q_item.addr = {root_table_addr[ADDR_W+2:12], 9'd0} + ADDR_W'({bus, 1'b0});
    end
  end

endmodule

`default_nettype wire

// ===== design/ioslw_queue.sv =====
// Short FIFO of classified items between front end and walker.
// Depends on ioslw_pkg.
`default_nettype none

module ioslw_queue
  import ioslw_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  push,
  input  wire item_t push_item,
  output      logic  full,
  input  wire logic  pop,
  output      logic  not_empty,
  output      item_t head
);

  item_t             slots [QDEPTH];
  logic [QPTR_W-1:0] wptr;
  logic [QPTR_W-1:0] rptr;
  logic [QCNT_W-1:0] count;

  assign full      = (count == QCNT_W'(QDEPTH));
  assign not_empty = (count != '0);
  assign head      = slots[rptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) wptr <= wptr + 1'b1;
      if (pop)  rptr <= rptr + 1'b1;
      if (push && !pop)      count <= count + 1'b1;
      else if (pop && !push) count <= count - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) slots[wptr] <= push_item;
  end

endmodule

`default_nettype wire

// ===== design/ioslw_walk.sv =====
// Back end: table store, root/context/PDPT walk sequencer and result register.
// Depends on ioslw_pkg.
`default_nettype none

module ioslw_walk
  import ioslw_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        q_valid,
  input  wire item_t       q_item,
  output      logic        q_pop,
  output      logic        out_valid,
  input  wire logic        out_ready,
  output      status_t     out_status,
  output      logic [63:0] out_pa
);

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_ROOT = 6'b000010,
    S_CLO  = 6'b000100,
    S_CHI  = 6'b001000,
    S_LEAF = 6'b010000,
    S_DONE = 6'b100000
  } state_t;

  state_t state;
  state_t state_next;

  logic [63:0] mem [STORE_WORDS];
  logic [63:0] rd_q;
  logic        mem_we;
  logic        mem_re;
  logic [ADDR_W-1:0] rd_addr;

  item_t             cur;
  logic [ADDR_W-1:0] ctx_word;
  logic [ADDR_W-1:0] ctx_word_next;
  logic [ADDR_W-1:0] pdpt_word;
  logic [ADDR_W-1:0] pdpt_word_next;

  status_t     res_status;
  logic [63:0] res_pa;

  logic        fin;
  status_t     fin_status;
  logic [63:0] fin_pa;
  logic        out_free;

  assign out_free = !out_valid || out_ready;

  always_comb begin
    state_next     = state;
    q_pop          = 1'b0;
    mem_we         = 1'b0;
    mem_re         = 1'b0;
    rd_addr        = '0;
    fin            = 1'b0;
    fin_status     = ST_OK;
    fin_pa         = '0;
    ctx_word_next  = ctx_word;
    pdpt_word_next = pdpt_word;
    case (state)
      S_IDLE: begin
        if (q_valid) begin
          q_pop = 1'b1;
          case (q_item.kind)
            K_WRITE: begin
              mem_we = q_item.wr_ok;
              fin    = 1'b1;
            end
            K_WALK: begin
              mem_re     = 1'b1;
              rd_addr    = q_item.addr;
              state_next = S_ROOT;
            end
            default: begin
              fin        = 1'b1;
              fin_status = q_item.status;
            end
          endcase
        end
      end
      S_ROOT: begin
        if (!rd_q[0]) begin
          fin        = 1'b1;
          fin_status = ST_NOT_PRESENT;
        end else begin
          // context entry: 4 KiB aligned base + ((dev << 3) | func) * 16 bytes
          ctx_word_next = {rd_q[ADDR_W+2:12], 9'd0} + ADDR_W'({cur.ctx_off, 1'b0});
          mem_re        = 1'b1;
          rd_addr       = ctx_word_next;
          state_next    = S_CLO;
        end
      end
      S_CLO: begin
        if (!rd_q[0]) begin
          fin        = 1'b1;
          fin_status = ST_NOT_PRESENT;
        end else begin
          pdpt_word_next = {rd_q[ADDR_W+2:12], 9'd0} + ADDR_W'(cur.pdx);
          mem_re         = 1'b1;
          rd_addr        = ctx_word + 1'b1;
          state_next     = S_CHI;
        end
      end
      S_CHI: begin
        if (rd_q[2:0] != AW_3LEVEL) begin
          fin        = 1'b1;
          fin_status = ST_UNSUPPORTED;
        end else if (cur.iova_bad) begin
          fin        = 1'b1;
          fin_status = ST_INVALID;
        end else begin
          mem_re     = 1'b1;
          rd_addr    = pdpt_word;
          state_next = S_LEAF;
        end
      end
      S_LEAF: begin
        fin = 1'b1;
        if (!rd_q[0]) begin
          fin_status = ST_NOT_PRESENT;
        end else if (!rd_q[7]) begin
          fin_status = ST_UNSUPPORTED;
        end else begin
          fin_pa = {rd_q[63:30], cur.iova_off};
        end
      end
      S_DONE: begin
        fin        = 1'b1;
        fin_status = res_status;
        fin_pa     = res_pa;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (fin && out_free) begin
        state     <= S_IDLE;
        out_valid <= 1'b1;
      end else begin
        state <= fin ? S_DONE : state_next;
        if (out_ready) out_valid <= 1'b0;
      end
    end
  end

  // payload, no reset
  always_ff @(posedge clk) begin
    if (q_pop) cur <= q_item;
    ctx_word  <= ctx_word_next;
    pdpt_word <= pdpt_word_next;
    if (fin) begin
      res_status <= fin_status;
      res_pa     <= fin_pa;
    end
    if (fin && out_free) begin
      out_status <= fin_status;
      out_pa     <= fin_pa;
    end
  end

  // single-port store, registered read
  always_ff @(posedge clk) begin
    if (mem_we) mem[q_item.addr] <= q_item.data;
    if (mem_re) rd_q <= mem[rd_addr];
  end

endmodule

`default_nettype wire

// ===== design/iommu_second_level_walk_core.sv =====
// A store write or a translation refused by the front end passes through the queue
// and then the result register; a full translation passes through the queue, the
// root, context low, context high and PDPT reads on the single store port, then the
// result register. The walker takes no new item until the last result is registered.
// Reset clears the queue, walker state, output valid and the config registers;
// the table store is not cleared and holds garbage until written.
`default_nettype none

module iommu_second_level_walk_core
  import ioslw_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 cfg_we,
  input  wire logic                 cfg_index,
  input  wire logic [63:0]          cfg_data,
  input  wire logic                 s_axis_tvalid,
  output      logic                 s_axis_tready,
  // word_index[11:0], word_data[75:12], bus[83:76], dev[91:84], func[99:92],
  // iova[163:100], zero pad
  input  wire logic [S_TDATA_W-1:0] s_axis_tdata,
  input  wire logic                 s_axis_tuser,  // req_type
  output      logic                 m_axis_tvalid,
  input  wire logic                 m_axis_tready,
  // status[2:0], phys_addr[66:3], zero pad
  output      logic [M_TDATA_W-1:0] m_axis_tdata
);

  logic        q_full;
  logic        q_push;
  item_t       push_item;
  logic        q_pop;
  logic        q_valid;
  item_t       head;
  status_t     out_status;
  logic [63:0] out_pa;

  ioslw_front u_front (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .q_full        (q_full),
    .q_push        (q_push),
    .q_item        (push_item)
  );

  ioslw_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_item (push_item),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_valid),
    .head      (head)
  );

  ioslw_walk u_walk (
    .clk        (clk),
    .rst        (rst),
    .q_valid    (q_valid),
    .q_item     (head),
    .q_pop      (q_pop),
    .out_valid  (m_axis_tvalid),
    .out_ready  (m_axis_tready),
    .out_status (out_status),
    .out_pa     (out_pa)
  );

  assign m_axis_tdata = {5'd0, out_pa, out_status};

endmodule

`default_nettype wire

// ===== design/ioslw_checker.sv =====
// Port-level checks for iommu_second_level_walk_core, bound to the top level.
// Depends on ioslw_pkg.
`default_nettype none

module ioslw_checker
  import ioslw_pkg::*;
(
  input wire logic                 clk,
  input wire logic                 rst,
  input wire logic                 m_axis_tvalid,
  input wire logic                 m_axis_tready,
  input wire logic [M_TDATA_W-1:0] m_axis_tdata
);

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed while stalled");

  a_reset: assert property (@(posedge clk) rst |=> !m_axis_tvalid)
    else $error("result valid after reset");

  a_status: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> m_axis_tdata[2:0] <= 3'(ST_UNSUPPORTED))
    else $error("status code out of range");

  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tdata[2:0] != 3'(ST_OK) |-> m_axis_tdata[66:3] == 64'd0)
    else $error("failed translation carries an address");

endmodule

bind iommu_second_level_walk_core ioslw_checker u_chk (.*);

`default_nettype wire
